// ----- rtl/core/mfr_pkg.sv -----
// shared constants, codes and types for the msb-first bit-field reader
// no dependencies; imported by mfr_front, mfr_back and the top level
package mfr_pkg;

    localparam int STORE_BYTES    = 64;
    localparam int MAX_FIELD_BITS = 32;

    localparam int CMD_W       = 2;
    localparam int DATA_W      = 8;
    localparam int COUNT_W     = 12;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int AVAIL_OUT_W = 10;

    localparam int IDX_W     = $clog2(STORE_BYTES);
    localparam int SB_W      = $clog2(STORE_BYTES + 1);
    localparam int AV_W      = SB_W + 3;
    localparam int CMP_W     = (AV_W > COUNT_W) ? AV_W : COUNT_W;
    localparam int WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
    localparam int WIN_BITS  = WIN_BYTES * 8;
    localparam int NB_W      = $clog2(WIN_BYTES + 1);

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_GET  = 2'd1,
        CMD_SKIP = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_TOO_WIDE = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // request class decided by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH,
        OP_GET,
        OP_SKIP,
        OP_WIDE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } t_item;

    typedef struct packed {
        logic [AV_W-1:0] avail;
    } t_back_mon;

    // unread bits: whole bytes held minus the bits already taken from the first
    function automatic logic [AV_W-1:0] avail_bits(input logic [SB_W-1:0] stored,
                                                   input logic [2:0]      offset);
        return {stored, 3'b000} - AV_W'(offset);
    endfunction

endpackage

// ----- rtl/core/mfr_front.sv -----
// front end: accepts requests, classifies them and holds them in a short queue
// depends on mfr_pkg
module mfr_front
    import mfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [DATA_W-1:0]  i_data_byte,
    input  logic [COUNT_W-1:0] i_bit_count,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_pop
);

    t_item            r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_cnt;
    t_item            n_item;
    logic             push;

    // classify: zero-length get or skip and the unused command do nothing
    always_comb begin
        n_item.data  = i_data_byte;
        n_item.count = i_bit_count;
        n_item.op    = OP_NOP;
        unique case (t_cmd'(i_cmd))
            CMD_PUSH: begin
                n_item.op = OP_PUSH;
            end
            CMD_GET: begin
                if (i_bit_count == '0) begin
                    n_item.op = OP_NOP;
                end else if (i_bit_count > COUNT_W'(MAX_FIELD_BITS)) begin
                    n_item.op = OP_WIDE;
                end else begin
                    n_item.op = OP_GET;
                end
            end
            CMD_SKIP: begin
                n_item.op = (i_bit_count == '0) ? OP_NOP : OP_SKIP;
            end
            CMD_NONE: begin
                n_item.op = OP_NOP;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == QC_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

endmodule

// ----- rtl/core/mfr_back.sv -----
// back end: byte ring store, read position and field extraction, output register
// depends on mfr_pkg; pops requests from mfr_front
module mfr_back
    import mfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_item                  i_q_item,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_W-1:0]     o_field_value,
    output logic [STATUS_W-1:0]    o_status,
    output logic [AVAIL_OUT_W-1:0] o_bits_available,
    output t_back_mon              o_mon
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } t_state;

    logic [DATA_W-1:0] r_mem [STORE_BYTES];

    t_state                    r_state, n_state;
    t_item                     r_item, n_item;
    logic [IDX_W-1:0]          r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]          r_wr_idx, n_wr_idx;
    logic [SB_W-1:0]           r_stored, n_stored;
    logic [2:0]                r_offset, n_offset;
    logic [IDX_W-1:0]          r_fetch_addr, n_fetch_addr;
    logic [NB_W-1:0]           r_left, n_left;
    logic                      r_rd_vld, n_rd_vld;
    logic [DATA_W-1:0]         r_rdata;
    logic [WIN_BITS-1:0]       r_win, n_win;
    logic [2:0]                r_sh, n_sh;
    logic                      r_out_valid, n_out_valid;
    logic [MAX_FIELD_BITS-1:0] r_out_value, n_out_value;
    t_status                   r_out_status, n_out_status;
    logic [AV_W-1:0]           r_out_avail, n_out_avail;

    logic                      mem_we;
    logic                      mem_re;
    logic                      out_free;
    logic                      short_req;
    logic [AV_W-1:0]           avail;
    logic [CMP_W:0]            tot;
    logic [SB_W-1:0]           whole;
    logic [SB_W:0]             idx_sum;
    logic [IDX_W-1:0]          adv_idx;
    logic [SB_W-1:0]           adv_stored;
    logic [NB_W-1:0]           nbytes;
    logic [MAX_FIELD_BITS-1:0] field_bits;

    always_comb begin
        avail      = avail_bits(r_stored, r_offset);
        short_req  = CMP_W'(r_item.count) > CMP_W'(avail);
        tot        = (CMP_W + 1)'(r_offset) + (CMP_W + 1)'(r_item.count);
        whole      = SB_W'(tot >> 3);
        idx_sum    = (SB_W + 1)'(r_rd_idx) + (SB_W + 1)'(whole);
        // sum stays below twice the store size, one subtract wraps it
        adv_idx    = (idx_sum >= (SB_W + 1)'(STORE_BYTES)) ?
                     IDX_W'(idx_sum - (SB_W + 1)'(STORE_BYTES)) : IDX_W'(idx_sum);
        adv_stored = r_stored - whole;
        nbytes     = NB_W'((tot + (CMP_W + 1)'(7)) >> 3);
        field_bits = MAX_FIELD_BITS'(r_win >> r_sh) &
                     ~({MAX_FIELD_BITS{1'b1}} << r_item.count);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_stored     = r_stored;
        n_offset     = r_offset;
        n_fetch_addr = r_fetch_addr;
        n_left       = r_left;
        n_win        = r_win;
        n_sh         = r_sh;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_avail  = r_out_avail;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        o_q_pop      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.op)
                    OP_PUSH: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_state     = S_IDLE;
                            if (r_stored == SB_W'(STORE_BYTES)) begin
                                n_out_status = ST_FULL;
                                n_out_avail  = avail;
                            end else begin
                                mem_we       = 1'b1;
                                n_wr_idx     = (r_wr_idx == IDX_W'(STORE_BYTES - 1)) ?
                                               '0 : r_wr_idx + 1'b1;
                                n_stored     = r_stored + 1'b1;
                                n_out_status = ST_OK;
                                n_out_avail  = avail_bits(r_stored + 1'b1, r_offset);
                            end
                        end
                    end
                    OP_GET: begin
                        if (short_req) begin
                            if (out_free) begin
                                n_out_valid  = 1'b1;
                                n_out_value  = '0;
                                n_out_status = ST_SHORT;
                                n_out_avail  = avail;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            n_fetch_addr = r_rd_idx;
                            n_left       = nbytes;
                            n_win        = '0;
                            n_sh         = 3'(3'd0 - tot[2:0]);
                            n_state      = S_FETCH;
                        end
                    end
                    OP_SKIP: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_state     = S_IDLE;
                            if (short_req) begin
                                n_out_status = ST_SHORT;
                                n_out_avail  = avail;
                            end else begin
                                n_rd_idx     = adv_idx;
                                n_stored     = adv_stored;
                                n_offset     = tot[2:0];
                                n_out_status = ST_OK;
                                n_out_avail  = avail_bits(adv_stored, tot[2:0]);
                            end
                        end
                    end
                    OP_WIDE: begin
                        if (out_free) begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = ST_TOO_WIDE;
                            n_out_avail  = avail;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = ST_OK;
                            n_out_avail  = avail;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_FETCH: begin
                // one byte read per cycle, its data registered and taken into the window in the next cycle
                if (r_left != '0) begin
                    mem_re       = 1'b1;
                    n_fetch_addr = (r_fetch_addr == IDX_W'(STORE_BYTES - 1)) ?
                                   '0 : r_fetch_addr + 1'b1;
                    n_left       = r_left - 1'b1;
                end
                if (r_rd_vld) begin
                    n_win = {r_win[WIN_BITS-DATA_W-1:0], r_rdata};
                end
                if (r_left == '0 && r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = field_bits;
                    n_out_status = ST_OK;
                    n_out_avail  = avail_bits(adv_stored, tot[2:0]);
                    n_rd_idx     = adv_idx;
                    n_stored     = adv_stored;
                    n_offset     = tot[2:0];
                    n_state      = S_IDLE;
                end
            end
        endcase

        n_rd_vld = mem_re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_stored    <= '0;
            r_offset    <= '0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_stored    <= n_stored;
            r_offset    <= n_offset;
            r_left      <= n_left;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_item       <= n_item;
        r_fetch_addr <= n_fetch_addr;
        r_win        <= n_win;
        r_sh         <= n_sh;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_avail  <= n_out_avail;
    end

    // byte ring store, registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= r_item.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_fetch_addr];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_field_value    = VALUE_W'(r_out_value);
    assign o_status         = r_out_status;
    assign o_bits_available = AVAIL_OUT_W'(r_out_avail);
    assign o_mon.avail      = avail;

endmodule

// ----- rtl/core/msb_first_bit_field_reader.sv -----
// top level of the msb-first bit-field reader: front end, request queue, back end
// depends on mfr_pkg, mfr_front and mfr_back
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------
// request  | in        | i_in_valid / o_in_stall | i_cmd, i_data_byte, i_bit_count
// result   | out       | o_out_valid/i_out_stall | o_field_value, o_status,
//          |           |                         | o_bits_available
//
// push, skip, zero-length and rejected requests go from idle through exec and back;
// a get reads nbytes = ceil((bit offset + count) / 8) bytes, 1 to 5, and 4 or 5
// for a 32-bit field, one at a time through the single read port of the byte store
// the front queue holds two requests, so requests are taken while the back end works
// reset is synchronous and active low; it empties the queue and the store
// a stalled result holds in the output register and the back end waits on it
module msb_first_bit_field_reader
    import mfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [DATA_W-1:0]      i_data_byte,
    input  logic [COUNT_W-1:0]     i_bit_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_W-1:0]     o_field_value,
    output logic [STATUS_W-1:0]    o_status,
    output logic [AVAIL_OUT_W-1:0] o_bits_available
);

    // classified requests between front and back
    logic      q_valid;
    t_item     q_item;
    logic      q_pop;
    t_back_mon back_mon;

    // front end: decode command, flag too-wide gets, queue the request
    mfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // back end: owns the ring store and read position, builds the result
    mfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_field_value    (o_field_value),
        .o_status         (o_status),
        .o_bits_available (o_bits_available),
        .o_mon            (back_mon)
    );

`ifndef SYNTH
    // back end never pops an empty queue
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // an accepted request is waiting in the queue on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> q_valid)
        else $error("accepted request missing from queue");

    // a pending result reports the back end's current bit count
    a_avail_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bits_available == AVAIL_OUT_W'(back_mon.avail)))
        else $error("reported bit count differs from store state");
`endif

endmodule
